@@ sv/bhs_pkg.sv @@
// bhs_pkg: shared types, constants and the sine table generator
// for the bipolar half-sine schedule generator. No dependencies.
`timescale 1ns / 1ps

package bhs_pkg;

    localparam int STEP_BITS      = 20;
    localparam int PHASE_BITS_DEF = 10;
    localparam int DATA_W         = 32;
    localparam int SINE_W         = 15;
    localparam int CNT_W          = $clog2(STEP_BITS + 1);
    localparam int QUEUE_DEPTH    = 2;
    localparam int ADDR_W         = 5;
    localparam int REG_IDX_W      = 3;

    localparam logic [REG_IDX_W-1:0] REG_OFFSET = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MOD    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SPS    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BAL    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_TOTAL  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MODE   = 3'd5;

    localparam logic [1:0] KIND_LEAD = 2'd0;
    localparam logic [1:0] KIND_FWD  = 2'd1;
    localparam logic [1:0] KIND_REV  = 2'd2;
    localparam logic [1:0] KIND_OUT  = 2'd3;

    localparam logic [STEP_BITS-1:0] STEP_MAX = '1;
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

    typedef struct packed {
        logic signed [DATA_W-1:0] offset;
        logic signed [DATA_W-1:0] modulation;
        logic [STEP_BITS-1:0]     sps;
        logic [STEP_BITS-1:0]     bal;
        logic [STEP_BITS-1:0]     total;
        logic                     mode;
    } t_cfg;

    typedef struct packed {
        logic                 start;
        logic [STEP_BITS-1:0] rem0;
        logic [STEP_BITS-1:0] num;
        logic [STEP_BITS-1:0] den;
        logic [CNT_W-1:0]     steps;
    } t_div_req;

    typedef struct packed {
        logic                 busy;
        logic [STEP_BITS-1:0] quo;
        logic [STEP_BITS-1:0] rem;
    } t_div_rsp;

    // (a*b) >> 60 for q60 operands
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    function automatic logic [63:0] term_div(input int n, input logic [63:0] v);
        logic [63:0] r;
        unique case (n)
            1:       r = v / 64'd6;
            2:       r = v / 64'd20;
            3:       r = v / 64'd42;
            4:       r = v / 64'd72;
            5:       r = v / 64'd110;
            6:       r = v / 64'd156;
            7:       r = v / 64'd210;
            8:       r = v / 64'd272;
            9:       r = v / 64'd342;
            10:      r = v / 64'd420;
            11:      r = v / 64'd506;
            12:      r = v / 64'd600;
            13:      r = v / 64'd702;
            14:      r = v / 64'd812;
            default: r = v;
        endcase
        return r;
    endfunction

    // elaboration-time taylor series for one table entry
    function automatic logic [SINE_W-1:0] sine_entry(input int k, input int pb);
        logic [63:0] size;
        logic [63:0] q;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        size = 64'd1 << pb;
        q    = 64'(k);
        if (q > (size >> 1)) begin
            q = size - q;
        end
        x    = (PI_Q60 >> pb) * q + (((PI_Q60 & (size - 64'd1)) * q) >> pb);
        x2   = mul_q60(x, x);
        term = x;
        sum  = x;
        for (int n = 1; n <= 14; n++) begin
            term = term_div(n, mul_q60(term, x2));
            if (n[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        v = (sum + (64'd1 << 44)) >> 45;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[SINE_W-1:0];
    endfunction

endpackage

@@ sv/bhs_div.sv @@
// bhs_div: restoring serial divider, one quotient bit per cycle,
// with a preset partial remainder. Depends on bhs_pkg.
`timescale 1ns / 1ps

module bhs_div
    import bhs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [STEP_BITS-1:0] r_rem;
    logic [STEP_BITS-1:0] r_num;
    logic [STEP_BITS-1:0] r_quo;

    logic [STEP_BITS:0]   partial;
    logic [STEP_BITS:0]   den_x;
    logic [STEP_BITS:0]   diff;
    logic                 ge;
    logic [STEP_BITS-1:0] n_rem;

    always_comb begin
        partial = {r_rem, r_num[STEP_BITS-1]};
        den_x   = {1'b0, i_req.den};
        diff    = partial - den_x;
        ge      = (partial >= den_x);
        n_rem   = ge ? diff[STEP_BITS-1:0] : partial[STEP_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_req.steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem0;
            r_num <= i_req.num;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_num <= {r_num[STEP_BITS-2:0], 1'b0};
            r_quo <= {r_quo[STEP_BITS-2:0], ge};
        end
    end

    assign o_rsp = '{busy: r_busy, quo: r_quo, rem: r_rem};

endmodule

@@ sv/bhs_fifo.sv @@
// bhs_fifo: short queue of tick indices between front and back.
// Depends on bhs_pkg.
`timescale 1ns / 1ps

module bhs_fifo
    import bhs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [STEP_BITS-1:0] i_tick,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_nonempty,
    output logic [STEP_BITS-1:0] o_tick
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_CNT = FILL_W'(QUEUE_DEPTH);

    logic [STEP_BITS-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]     r_wr;
    logic [PTR_W-1:0]     r_rd;
    logic [FILL_W-1:0]    r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + FILL_W'(1);
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_tick;
        end
    end

    assign o_full     = (r_fill == FULL_CNT);
    assign o_nonempty = (r_fill != '0);
    assign o_tick     = r_mem[r_rd];

endmodule

@@ sv/bhs_front.sv @@
// bhs_front: accepts input words, applies restart and keeps the
// saturating tick counter. Depends on bhs_pkg.
`timescale 1ns / 1ps

module bhs_front
    import bhs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_restart,
    input  logic                 i_q_full,
    output logic                 o_ready,
    output logic                 o_push,
    output logic [STEP_BITS-1:0] o_tick
);

    logic [STEP_BITS-1:0] r_tick;
    logic [STEP_BITS-1:0] n_tick;
    logic [STEP_BITS-1:0] cur;

    always_comb begin
        cur    = i_restart ? '0 : r_tick;
        n_tick = (cur != STEP_MAX) ? cur + STEP_BITS'(1) : STEP_MAX;
    end

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;
    assign o_tick  = cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
        end else if (o_push) begin
            r_tick <= n_tick;
        end
    end

endmodule

@@ sv/bhs_back.sv @@
// bhs_back: classifies each queued tick with the serial dividers, in mode 1
// reads the half-sine table and scales, saturates and holds the result word.
// Depends on bhs_pkg and bhs_div.
`timescale 1ns / 1ps

module bhs_back
    import bhs_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  logic                     i_q_nonempty,
    input  logic [STEP_BITS-1:0]     i_q_tick,
    output logic                     o_pop,
    input  logic                     i_ready,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_voltage,
    output logic [STEP_BITS-1:0]     o_tick_index,
    output logic [1:0]               o_segment_kind
);

    localparam int ROM_DEPTH = 1 << PHASE_BITS;
    localparam int PROD_W    = DATA_W + SINE_W + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_IDX  = 3'd2;
    localparam logic [2:0] S_ROM  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    typedef logic [SINE_W-1:0] t_rom [ROM_DEPTH];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int k = 0; k < ROM_DEPTH; k++) begin
            rom[k] = sine_entry(k, PHASE_BITS);
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    logic [2:0]               r_state;
    logic [2:0]               n_state;
    logic [STEP_BITS-1:0]     r_t;
    logic [STEP_BITS-1:0]     r_used;
    logic [1:0]               r_kind;
    logic [PHASE_BITS-1:0]    r_idx;
    logic [SINE_W-1:0]        r_sine;
    logic signed [PROD_W-1:0] r_prod;

    logic                     r_o_valid;
    logic signed [DATA_W-1:0] r_o_voltage;
    logic [STEP_BITS-1:0]     r_o_tick;
    logic [1:0]               r_o_kind;

    t_div_req req_a;
    t_div_req req_b;
    t_div_rsp rsp_a;
    t_div_rsp rsp_b;

    logic [STEP_BITS-1:0]     rem_len;
    logic [STEP_BITS-1:0]     used_c;
    logic [STEP_BITS-1:0]     d_c;
    logic [1:0]               kind_c;
    logic                     load_out;
    logic signed [PROD_W-1:0] rounded;
    logic signed [DATA_W:0]   swing;
    logic signed [DATA_W+1:0] sum_v;
    logic signed [DATA_W-1:0] volt_c;

    bhs_div u_div_a (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_a), .o_rsp(rsp_a));
    bhs_div u_div_b (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_b), .o_rsp(rsp_b));

    // segment length and lead-in offset of the tick at the queue head
    always_comb begin
        rem_len = i_cfg.total - i_cfg.bal;
        if (i_cfg.total > i_cfg.bal) begin
            used_c = (i_cfg.sps < rem_len) ? i_cfg.sps : rem_len;
        end else begin
            used_c = '0;
        end
        d_c = i_q_tick - i_cfg.bal;
    end

    always_comb begin
        priority if (!((r_used != '0) && (r_t < i_cfg.total))) begin
            kind_c = KIND_OUT;
        end else if (r_t < i_cfg.bal) begin
            kind_c = KIND_LEAD;
        end else if (rsp_b.quo < rsp_a.quo) begin
            kind_c = rsp_b.quo[0] ? KIND_REV : KIND_FWD;
        end else begin
            kind_c = KIND_OUT;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        load_out = 1'b0;
        req_a    = '{start: 1'b0, rem0: '0, num: rem_len, den: r_used,
                     steps: CNT_W'(STEP_BITS)};
        req_b    = '{start: 1'b0, rem0: '0, num: d_c, den: r_used,
                     steps: CNT_W'(STEP_BITS)};
        unique case (r_state)
            S_IDLE: begin
                if (i_q_nonempty) begin
                    o_pop       = 1'b1;
                    req_a.start = 1'b1;
                    req_b.start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (!rsp_a.busy && !rsp_b.busy) begin
                    req_b.start = 1'b1;
                    req_b.rem0  = rsp_b.rem;
                    req_b.num   = '0;
                    req_b.steps = CNT_W'(PHASE_BITS);
                    n_state     = S_IDX;
                end
            end
            S_IDX: begin
                if (!rsp_b.busy) begin
                    n_state = S_ROM;
                end
            end
            S_ROM: n_state = S_MUL;
            S_MUL: n_state = S_OUT;
            S_OUT: begin
                if (!r_o_valid || i_ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_t    <= i_q_tick;
            r_used <= used_c;
        end
        if (r_state == S_DIV) begin
            r_kind <= kind_c;
        end
        if (r_state == S_IDX) begin
            r_idx <= rsp_b.quo[PHASE_BITS-1:0];
        end
        r_sine <= SINE_ROM[r_idx];
        r_prod <= i_cfg.modulation * $signed({1'b0, r_sine});
    end

    // swing, polarity and saturation
    always_comb begin
        rounded = r_prod + PROD_W'(16384);
        if (i_cfg.mode) begin
            swing = {rounded[PROD_W-2], rounded[PROD_W-2:SINE_W]};
        end else begin
            swing = {i_cfg.modulation[DATA_W-1], i_cfg.modulation};
        end
        if (r_kind == KIND_FWD) begin
            sum_v = {{2{i_cfg.offset[DATA_W-1]}}, i_cfg.offset} - {swing[DATA_W], swing};
        end else begin
            sum_v = {{2{i_cfg.offset[DATA_W-1]}}, i_cfg.offset} + {swing[DATA_W], swing};
        end
        priority if (r_kind != KIND_FWD && r_kind != KIND_REV) begin
            volt_c = '0;
        end else if (sum_v > (DATA_W+2)'(32'sh7FFF_FFFF)) begin
            volt_c = 32'sh7FFF_FFFF;
        end else if (sum_v < -(DATA_W+2)'(34'sh0_8000_0000)) begin
            volt_c = 32'sh8000_0000;
        end else begin
            volt_c = sum_v[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load_out) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_voltage <= volt_c;
            r_o_tick    <= r_t;
            r_o_kind    <= r_kind;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_voltage      = r_o_voltage;
    assign o_tick_index   = r_o_tick;
    assign o_segment_kind = r_o_kind;

endmodule

@@ sv/bipolar_half_sine_schedule_gen_top.sv @@
// each word goes through the serial dividers (segment split, then sine phase) and
// then the table read and multiply; the back end finishes one tick before it pops
// the next, and a two-entry queue lets input words be taken while a result waits
// reset: synchronous active low, clears the tick counter, queue, control state and
// loads register defaults; the sine table is constant and needs no fill
`timescale 1ns / 1ps

module bipolar_half_sine_schedule_gen_top
    import bhs_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_restart,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [DATA_W-1:0] o_voltage,
    output logic [STEP_BITS-1:0]     o_tick_index,
    output logic [1:0]               o_segment_kind,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready
);

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    logic                 q_full;
    logic                 q_nonempty;
    logic                 push;
    logic                 pop;
    logic [STEP_BITS-1:0] push_tick;
    logic [STEP_BITS-1:0] head_tick;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset     <= '0;
            r_cfg.modulation <= '0;
            r_cfg.sps        <= STEP_BITS'(1);
            r_cfg.bal        <= '0;
            r_cfg.total      <= '0;
            r_cfg.mode       <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_OFFSET: r_cfg.offset     <= pwdata;
                REG_MOD:    r_cfg.modulation <= pwdata;
                REG_SPS:    r_cfg.sps        <= pwdata[STEP_BITS-1:0];
                REG_BAL:    r_cfg.bal        <= pwdata[STEP_BITS-1:0];
                REG_TOTAL:  r_cfg.total      <= pwdata[STEP_BITS-1:0];
                REG_MODE:   r_cfg.mode       <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_OFFSET: prdata = r_cfg.offset;
            REG_MOD:    prdata = r_cfg.modulation;
            REG_SPS:    prdata = {{(DATA_W-STEP_BITS){1'b0}}, r_cfg.sps};
            REG_BAL:    prdata = {{(DATA_W-STEP_BITS){1'b0}}, r_cfg.bal};
            REG_TOTAL:  prdata = {{(DATA_W-STEP_BITS){1'b0}}, r_cfg.total};
            REG_MODE:   prdata = {{(DATA_W-1){1'b0}}, r_cfg.mode};
            default:    prdata = '0;
        endcase
    end

    bhs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_restart (i_restart),
        .i_q_full  (q_full),
        .o_ready   (o_ready),
        .o_push    (push),
        .o_tick    (push_tick)
    );

    bhs_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_tick     (push_tick),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_tick     (head_tick)
    );

    bhs_back #(
        .PHASE_BITS (PHASE_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_nonempty   (q_nonempty),
        .i_q_tick       (head_tick),
        .o_pop          (pop),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_voltage      (o_voltage),
        .o_tick_index   (o_tick_index),
        .o_segment_kind (o_segment_kind)
    );

endmodule

@@ sv/bhs_chk.sv @@
// bhs_chk: port-level assertions for the schedule generator top level,
// attached by bind. Depends on bhs_pkg.
`timescale 1ns / 1ps

module bhs_chk
    import bhs_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_ready,
    input logic                     o_valid,
    input logic                     o_ready,
    input logic signed [DATA_W-1:0] o_voltage,
    input logic [STEP_BITS-1:0]     o_tick_index,
    input logic [1:0]               o_segment_kind
);

    a_reset_state: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!o_valid && o_ready))
        else $error("output word or full queue right after reset");

    a_zero_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_segment_kind == KIND_LEAD || o_segment_kind == KIND_OUT))
            |-> (o_voltage == '0))
        else $error("non-zero voltage on lead-in or outside word");

    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
            (o_valid && $stable(o_voltage) && $stable(o_tick_index)
             && $stable(o_segment_kind)))
        else $error("stalled result word changed");

    a_drop_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_valid) |-> $past(i_ready))
        else $error("result word dropped without being taken");

endmodule

bind bipolar_half_sine_schedule_gen_top bhs_chk u_bhs_chk (.*);

@@ tb/testbench.sv @@
// self-checking bench for bipolar_half_sine_schedule_gen_top: directed table, then
// mostly random config phases with restart-driven runs, checked against a local tick
// predictor; depends on bhs_pkg and the dut only
`timescale 1ns / 1ps

module testbench;
    import bhs_pkg::*;

    localparam int PHASE_W         = PHASE_BITS_DEF;
    localparam int PAD_CYCLES      = STEP_BITS + PHASE_W + 16;
    localparam int HANG_LIMIT      = 4000;
    localparam int PHASES          = 10;
    localparam int WORDS_PER_PHASE = 108;
    localparam int QUIET_PHASE     = 4;

    typedef struct {
        logic signed [DATA_W-1:0] voltage;
        logic [STEP_BITS-1:0]     tick;
        logic [1:0]               kind;
    } t_drive_word;

    typedef struct {
        logic                 is_reg;
        logic [REG_IDX_W-1:0] idx;
        logic [DATA_W-1:0]    value;
        logic                 restart;
        logic                 typed;
        t_drive_word          want;
    } t_plan_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_ready;
    logic                     i_restart;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic signed [DATA_W-1:0] o_voltage;
    logic [STEP_BITS-1:0]     o_tick_index;
    logic [1:0]               o_segment_kind;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [ADDR_W-1:0]        paddr;
    logic [DATA_W-1:0]        pwdata;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;

    logic [SINE_W-1:0]    half_sine [0:(1 << PHASE_W)-1];
    t_cfg                 cfg;
    logic [STEP_BITS-1:0] tick_now;
    t_drive_word          owed_drive [$];
    t_drive_word          seen_word;
    t_drive_word          owed_word;
    t_drive_word          fresh_word;
    t_drive_word          row_word;
    logic                 row_typed;
    logic                 stall_en;
    t_plan_row            plan [$];
    int                   drv_tick;
    int                   mismatches;
    int                   quiet_cycles;

    bipolar_half_sine_schedule_gen_top #(
        .PHASE_BITS(PHASE_W)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_restart(i_restart),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_voltage(o_voltage),
        .o_tick_index(o_tick_index),
        .o_segment_kind(o_segment_kind),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // q60 taylor series, folded about the quarter wave
    function automatic logic [SINE_W-1:0] sine_sample(input int k);
        logic [127:0] wide;
        logic [63:0]  q;
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  term;
        logic [63:0]  sum;
        logic [63:0]  v;
        q = 64'(k);
        if (q > (64'd1 << (PHASE_W - 1))) begin
            q = (64'd1 << PHASE_W) - q;
        end
        wide = {64'd0, PI_Q60} * {64'd0, q};
        x    = 64'(wide >> PHASE_W);
        wide = {64'd0, x} * {64'd0, x};
        x2   = wide[123:60];
        term = x;
        sum  = x;
        for (int n = 1; n <= 14; n++) begin
            wide = {64'd0, term} * {64'd0, x2};
            term = wide[123:60] / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        v = (sum + (64'd1 << 44)) >> 45;
        return (v > 64'd32767) ? SINE_W'(32767) : v[SINE_W-1:0];
    endfunction

    function automatic t_drive_word next_drive(input logic restart);
        t_drive_word       w;
        logic [STEP_BITS-1:0] t;
        longint unsigned   span;
        longint unsigned   seglen;
        longint unsigned   nfull;
        longint unsigned   d;
        longint unsigned   seg;
        longint unsigned   pos;
        longint unsigned   idx;
        longint signed     off;
        longint signed     amp;
        longint signed     entry;
        longint signed     swing;
        longint signed     level;
        t      = restart ? '0 : tick_now;
        span   = 0;
        seglen = 0;
        nfull  = 0;
        level  = 0;
        w.kind = KIND_OUT;
        off    = longint'(cfg.offset);
        amp    = longint'(cfg.modulation);
        if (cfg.total > cfg.bal) begin
            span   = 64'(cfg.total) - 64'(cfg.bal);
            seglen = (64'(cfg.sps) < span) ? 64'(cfg.sps) : span;
            if (seglen != 0) begin
                nfull = span / seglen;
            end
        end
        if (seglen != 0 && t < cfg.total) begin
            if (t < cfg.bal) begin
                w.kind = KIND_LEAD;
            end else begin
                d   = 64'(t) - 64'(cfg.bal);
                seg = d / seglen;
                pos = d % seglen;
                if (seg < nfull) begin
                    w.kind = seg[0] ? KIND_REV : KIND_FWD;
                    if (cfg.mode) begin
                        idx   = (pos << PHASE_W) / seglen;
                        entry = longint'(half_sine[idx[PHASE_W-1:0]]);
                        swing = (amp * entry + 64'sd16384) >>> 15;
                    end else begin
                        swing = amp;
                    end
                    level = (w.kind == KIND_FWD) ? off - swing : off + swing;
                    if (level > 64'sd2147483647) begin
                        level = 64'sd2147483647;
                    end
                    if (level < -64'sd2147483648) begin
                        level = -64'sd2147483648;
                    end
                end
            end
        end
        w.voltage = level[DATA_W-1:0];
        w.tick    = t;
        tick_now  = (t < STEP_MAX) ? t + 1'b1 : STEP_MAX;
        return w;
    endfunction

    function automatic t_plan_row word_row(input logic restart, input logic typed,
                                           input logic [DATA_W-1:0] volts, input int tk,
                                           input logic [1:0] kind);
        t_plan_row r;
        r.is_reg       = 1'b0;
        r.idx          = REG_OFFSET;
        r.value        = '0;
        r.restart      = restart;
        r.typed        = typed;
        r.want.voltage = volts;
        r.want.tick    = STEP_BITS'(tk);
        r.want.kind    = kind;
        return r;
    endfunction

    function automatic t_plan_row cfg_row(input logic [REG_IDX_W-1:0] idx,
                                          input logic [DATA_W-1:0] value);
        t_plan_row r;
        r        = word_row(1'b0, 1'b0, '0, 0, KIND_OUT);
        r.is_reg = 1'b1;
        r.idx    = idx;
        r.value  = value;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want,
                                   input int at_tick);
        mismatches++;
        $display("%0t tick %0d: %s got %0h want %0h", $time, at_tick, field, got, want);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_OFFSET: cfg.offset     = value;
            REG_MOD:    cfg.modulation = value;
            REG_SPS:    cfg.sps        = value[STEP_BITS-1:0];
            REG_BAL:    cfg.bal        = value[STEP_BITS-1:0];
            REG_TOTAL:  cfg.total      = value[STEP_BITS-1:0];
            REG_MODE:   cfg.mode       = value[0];
            default:    ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic send_word(input logic restart, input logic typed, input t_drive_word want);
        while (stall_en && $urandom_range(0, 99) < 11) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        row_typed = typed;
        row_word  = want;
        i_valid   <= 1'b1;
        i_restart <= restart;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        drv_tick = restart ? 1 : drv_tick + 1;
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (owed_drive.size() != 0) @(negedge i_clk);
        repeat (PAD_CYCLES) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_ready <= (stall_en && $urandom_range(0, 99) < 11) ? 1'b0 : 1'b1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_now     = '0;
            quiet_cycles = 0;
        end else begin
            if (o_valid && i_ready) begin
                seen_word.voltage = o_voltage;
                seen_word.tick    = o_tick_index;
                seen_word.kind    = o_segment_kind;
                if (owed_drive.size() == 0) begin
                    report_mismatch("unexpected word", o_voltage, 0, o_tick_index);
                end else begin
                    owed_word = owed_drive.pop_front();
                    if (seen_word.voltage !== owed_word.voltage) begin
                        report_mismatch("voltage", seen_word.voltage, owed_word.voltage,
                                        owed_word.tick);
                    end
                    if (seen_word.tick !== owed_word.tick) begin
                        report_mismatch("tick index", seen_word.tick, owed_word.tick,
                                        owed_word.tick);
                    end
                    if (seen_word.kind !== owed_word.kind) begin
                        report_mismatch("segment kind", seen_word.kind, owed_word.kind,
                                        owed_word.tick);
                    end
                end
            end
            if (i_valid && o_ready) begin
                fresh_word = next_drive(i_restart);
                if (row_typed) begin
                    fresh_word = row_word;
                end
                owed_drive.push_back(fresh_word);
            end
            if ((o_valid && i_ready) || (i_valid && o_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        t_drive_word       blank;
        logic              restart;
        logic [DATA_W-1:0] off;
        logic [DATA_W-1:0] amp;
        logic [STEP_BITS-1:0] sps;
        logic [STEP_BITS-1:0] bal;
        logic [STEP_BITS-1:0] total;
        logic              mode;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_restart      = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        row_typed      = 1'b0;
        stall_en       = 1'b1;
        drv_tick       = 0;
        mismatches     = 0;
        blank          = '{voltage: '0, tick: '0, kind: KIND_OUT};
        row_word       = blank;
        cfg.offset     = '0;
        cfg.modulation = '0;
        cfg.sps        = STEP_BITS'(1);
        cfg.bal        = '0;
        cfg.total      = '0;
        cfg.mode       = 1'b0;
        for (int k = 0; k < (1 << PHASE_W); k++) begin
            half_sine[k] = sine_sample(k);
        end

        // reset values: empty schedule
        plan.push_back(word_row(1'b0, 1'b1, 32'h0, 0, KIND_OUT));
        plan.push_back(word_row(1'b0, 1'b1, 32'h0, 1, KIND_OUT));
        plan.push_back(word_row(1'b1, 1'b1, 32'h0, 0, KIND_OUT));
        // square, saturating both ways
        plan.push_back(cfg_row(REG_OFFSET, 32'h7FFF_FFFF));
        plan.push_back(cfg_row(REG_MOD, 32'h8000_0000));
        plan.push_back(cfg_row(REG_SPS, 32'd2));
        plan.push_back(cfg_row(REG_BAL, 32'd1));
        plan.push_back(cfg_row(REG_TOTAL, 32'd6));
        plan.push_back(word_row(1'b1, 1'b1, 32'h0, 0, KIND_LEAD));
        plan.push_back(word_row(1'b0, 1'b1, 32'h7FFF_FFFF, 1, KIND_FWD));
        plan.push_back(word_row(1'b0, 1'b1, 32'h7FFF_FFFF, 2, KIND_FWD));
        plan.push_back(word_row(1'b0, 1'b1, 32'hFFFF_FFFF, 3, KIND_REV));
        plan.push_back(word_row(1'b0, 1'b1, 32'hFFFF_FFFF, 4, KIND_REV));
        plan.push_back(word_row(1'b0, 1'b1, 32'h0, 5, KIND_OUT));
        plan.push_back(word_row(1'b0, 1'b1, 32'h0, 6, KIND_OUT));
        plan.push_back(cfg_row(REG_OFFSET, 32'h8000_0000));
        plan.push_back(cfg_row(REG_MOD, 32'h7FFF_FFFF));
        plan.push_back(word_row(1'b1, 1'b1, 32'h0, 0, KIND_LEAD));
        plan.push_back(word_row(1'b0, 1'b1, 32'h8000_0000, 1, KIND_FWD));
        plan.push_back(word_row(1'b0, 1'b1, 32'h8000_0000, 2, KIND_FWD));
        plan.push_back(word_row(1'b0, 1'b1, 32'hFFFF_FFFF, 3, KIND_REV));
        // half-sine segments
        plan.push_back(cfg_row(REG_MODE, 32'd1));
        plan.push_back(cfg_row(REG_OFFSET, 32'h0));
        plan.push_back(cfg_row(REG_MOD, 32'h0001_0000));
        plan.push_back(cfg_row(REG_SPS, 32'd8));
        plan.push_back(cfg_row(REG_BAL, 32'd0));
        plan.push_back(cfg_row(REG_TOTAL, 32'd20));
        plan.push_back(word_row(1'b1, 1'b0, 32'h0, 0, KIND_OUT));
        for (int n = 0; n < 5; n++) begin
            plan.push_back(word_row(1'b0, 1'b0, 32'h0, 0, KIND_OUT));
        end
        // bad lengths
        plan.push_back(cfg_row(REG_TOTAL, 32'd5));
        plan.push_back(cfg_row(REG_BAL, 32'd5));
        plan.push_back(word_row(1'b1, 1'b1, 32'h0, 0, KIND_OUT));
        plan.push_back(cfg_row(REG_BAL, 32'd0));
        plan.push_back(cfg_row(REG_SPS, 32'd0));
        plan.push_back(word_row(1'b1, 1'b1, 32'h0, 0, KIND_OUT));
        // longest requested segment, clipped to the run
        plan.push_back(cfg_row(REG_SPS, 32'h000F_FFFF));
        plan.push_back(cfg_row(REG_BAL, 32'd2));
        plan.push_back(cfg_row(REG_TOTAL, 32'd10));
        plan.push_back(word_row(1'b1, 1'b0, 32'h0, 0, KIND_OUT));
        plan.push_back(word_row(1'b0, 1'b0, 32'h0, 0, KIND_OUT));
        plan.push_back(word_row(1'b0, 1'b0, 32'h0, 0, KIND_OUT));

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[r]) begin
            if (plan[r].is_reg) begin
                settle();
                write_reg(plan[r].idx, plan[r].value);
            end else begin
                send_word(plan[r].restart, plan[r].typed, plan[r].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            if (ph == 0) begin
                sps   = '1;
                bal   = '0;
                total = '1;
                mode  = 1'b1;
                off   = $urandom;
                amp   = 32'h8000_0000;
            end else if (ph == 1) begin
                sps   = STEP_BITS'($urandom);
                bal   = STEP_BITS'($urandom);
                total = STEP_BITS'($urandom);
                mode  = 1'($urandom_range(0, 1));
                off   = $urandom;
                amp   = $urandom;
            end else if (ph == PHASES - 1) begin
                sps   = STEP_BITS'(1);
                bal   = '0;
                total = '1;
                mode  = 1'b0;
                off   = '0;
                amp   = 32'h7FFF_FFFF;
            end else begin
                sps   = ($urandom_range(0, 3) == 0) ? STEP_BITS'($urandom_range(17, 100))
                                                    : STEP_BITS'($urandom_range(1, 16));
                bal   = STEP_BITS'($urandom_range(0, 10));
                total = bal + STEP_BITS'($urandom_range(0, 80));
                mode  = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 1) == 1) begin
                    off = $urandom;
                    amp = $urandom;
                end else begin
                    off = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
                    amp = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
                end
            end
            write_reg(REG_OFFSET, off);
            write_reg(REG_MOD, amp);
            write_reg(REG_SPS, DATA_W'(sps));
            write_reg(REG_BAL, DATA_W'(bal));
            write_reg(REG_TOTAL, DATA_W'(total));
            write_reg(REG_MODE, DATA_W'(mode));
            stall_en = (ph != QUIET_PHASE);
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                // mostly whole runs past the end, with the odd early restart
                restart = (drv_tick > int'(cfg.total) + $urandom_range(0, 3))
                          || ($urandom_range(0, 39) == 0);
                send_word(restart, 1'b0, blank);
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/bhs_pkg.sv
sv/bhs_div.sv
sv/bhs_fifo.sv
sv/bhs_front.sv
sv/bhs_back.sv
sv/bipolar_half_sine_schedule_gen_top.sv
sv/bhs_chk.sv
tb/testbench.sv
